// ===== hdl/lpim_pkg.sv =====
// ----------------------------------------------------------------------------
// lpim_pkg
// Shared constants for the logarithmic palette index map: register indexes,
// mode codes and the fixed-point formats of the log and root datapath.
// ----------------------------------------------------------------------------
package lpim_pkg;

  localparam int COUNT_BITS_DEF    = 32;
  localparam int FRACTION_BITS_DEF = 16;

  localparam int DATA_W    = 32;
  localparam int CFG_IDX_W = 2;
  localparam int SCALE_W   = 25;

  // log2 by repeated squaring: mantissa in [1,2) as Q61
  localparam int Y_W       = 62;
  localparam int Y_LO_W    = 31;
  localparam int Y_HI_W    = Y_W - Y_LO_W;
  localparam int LOG2_FRAC = 56;
  localparam int SH_W      = 6;
  localparam int K_FIELD_W = 5;
  localparam int V_W       = K_FIELD_W + LOG2_FRAC;

  localparam logic [63:0] LN2_Q64 = 64'hB17217F7D1CF79AB;

  localparam logic [CFG_IDX_W-1:0] REG_MAP_MODE    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COUNT_LIMIT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LOW_OFFSET  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SCALE       = 2'd3;

  localparam logic [1:0] MODE_PASS      = 2'd0;
  localparam logic [1:0] MODE_OFFSET_LOG = 2'd1;
  localparam logic [1:0] MODE_PLAIN_LOG = 2'd2;
  localparam logic [1:0] MODE_SQRT      = 2'd3;

endpackage

// ===== hdl/lpim_iter.sv =====
// ----------------------------------------------------------------------------
// lpim_iter
// One two-stage slice of the map pipeline: a squaring step of the log2
// mantissa (products, then sum and renormalize) and optionally one digit of
// the restoring square root, with the beat's side data carried alongside.
// ----------------------------------------------------------------------------
module lpim_iter import lpim_pkg::*; #(
  parameter int CW      = COUNT_BITS_DEF,
  parameter int KW      = 5,
  parameter int ROOT_W  = 32,
  parameter bit DO_ROOT = 1'b1
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  en,
  input  logic                  i_valid,
  input  logic [CW-1:0]         i_c,
  input  logic [CW-1:0]         i_x,
  input  logic [KW-1:0]         i_k,
  input  logic [Y_W-1:0]        i_y,
  input  logic [LOG2_FRAC-1:0]  i_frac,
  input  logic [ROOT_W+2:0]     i_rem,
  input  logic [ROOT_W-1:0]     i_root,
  input  logic [2*ROOT_W-1:0]   i_rad,
  output logic                  o_valid,
  output logic [CW-1:0]         o_c,
  output logic [CW-1:0]         o_x,
  output logic [KW-1:0]         o_k,
  output logic [Y_W-1:0]        o_y,
  output logic [LOG2_FRAC-1:0]  o_frac,
  output logic [ROOT_W+2:0]     o_rem,
  output logic [ROOT_W-1:0]     o_root,
  output logic [2*ROOT_W-1:0]   o_rad
);

  localparam int RW   = ROOT_W + 3;
  localparam int RADW = 2 * ROOT_W;
  localparam int PW   = 2 * Y_HI_W;
  localparam int SW   = 2 * Y_W;

  logic                 va_r;
  logic [CW-1:0]        ca_r, xa_r;
  logic [KW-1:0]        ka_r;
  logic [LOG2_FRAC-1:0] fa_r;
  logic [RW-1:0]        rema_r;
  logic [ROOT_W-1:0]    roota_r;
  logic [RADW-1:0]      rada_r;
  logic [PW-1:0]        hh_r, hl_r, ll_r;

  logic                 vb_r;
  logic [CW-1:0]        cb_r, xb_r;
  logic [KW-1:0]        kb_r;
  logic [Y_W-1:0]       yb_r;
  logic [LOG2_FRAC-1:0] fb_r;
  logic [RW-1:0]        remb_r;
  logic [ROOT_W-1:0]    rootb_r;
  logic [RADW-1:0]      radb_r;

  logic [Y_W-1:0]       y_nxt;
  logic                 bit_nxt;
  logic [RW-1:0]        rem_nxt;
  logic [ROOT_W-1:0]    root_nxt;
  logic [RADW-1:0]      rad_nxt;

  // stage a: partial products of the square
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
    end else if (en) begin
      va_r <= i_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ca_r    <= i_c;
      xa_r    <= i_x;
      ka_r    <= i_k;
      fa_r    <= i_frac;
      rema_r  <= i_rem;
      roota_r <= i_root;
      rada_r  <= i_rad;
      hh_r    <= PW'(i_y[Y_W-1:Y_LO_W]) * PW'(i_y[Y_W-1:Y_LO_W]);
      hl_r    <= PW'(i_y[Y_W-1:Y_LO_W]) * PW'(i_y[Y_LO_W-1:0]);
      ll_r    <= PW'(i_y[Y_LO_W-1:0]) * PW'(i_y[Y_LO_W-1:0]);
    end
  end

  // stage b: sum, renormalize, root digit
  always_comb begin
    logic [SW-1:0] sq;
    logic [Y_W:0]  t;
    logic [RW-1:0] rem_sh;
    logic [RW-1:0] trial;
    sq      = (SW'(hh_r) << (2 * Y_LO_W)) + (SW'(hl_r) << (Y_LO_W + 1)) + SW'(ll_r);
    t       = sq[Y_W-1 +: Y_W+1];
    bit_nxt = t[Y_W];
    y_nxt   = bit_nxt ? t[Y_W:1] : t[Y_W-1:0];
    rem_sh  = {rema_r[RW-3:0], rada_r[RADW-1 -: 2]};
    trial   = {RW'(roota_r) << 2} | RW'(1);
    rad_nxt = rada_r << 2;
    if (!DO_ROOT) begin
      rem_nxt  = rema_r;
      root_nxt = roota_r;
      rad_nxt  = rada_r;
    end else if (rem_sh >= trial) begin
      rem_nxt  = rem_sh - trial;
      root_nxt = {roota_r[ROOT_W-2:0], 1'b1};
    end else begin
      rem_nxt  = rem_sh;
      root_nxt = {roota_r[ROOT_W-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vb_r <= 1'b0;
    end else if (en) begin
      vb_r <= va_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cb_r    <= ca_r;
      xb_r    <= xa_r;
      kb_r    <= ka_r;
      yb_r    <= y_nxt;
      fb_r    <= {fa_r[LOG2_FRAC-2:0], bit_nxt};
      remb_r  <= rem_nxt;
      rootb_r <= root_nxt;
      radb_r  <= rad_nxt;
    end
  end

  assign o_valid = vb_r;
  assign o_c     = cb_r;
  assign o_x     = xb_r;
  assign o_k     = kb_r;
  assign o_y     = yb_r;
  assign o_frac  = fb_r;
  assign o_rem   = remb_r;
  assign o_root  = rootb_r;
  assign o_rad   = radb_r;

endmodule

// ===== hdl/log_palette_index_map.sv =====
// ----------------------------------------------------------------------------
// log_palette_index_map
// Maps an escape-iteration count to a palette index by pass-through, log
// with offset, plain log or square-root curves, in fixed point.
// ----------------------------------------------------------------------------
// One beat is accepted per cycle unless halted; each gives one result through
// three front stages (input register, clamp and offset, normalize), 56 log2
// squaring steps of two stages each, the first ROOT_W also forming root digits,
// then three stages of ln2 scaling and palette-scale products and the output
// register. The whole pipeline halts while a finished result waits at output.
// ----------------------------------------------------------------------------
module log_palette_index_map import lpim_pkg::*; #(
  parameter int COUNT_BITS    = COUNT_BITS_DEF,
  parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [COUNT_BITS-1:0] in_iteration_count,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [DATA_W-1:0]     out_color_index,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [DATA_W-1:0]     cfg_data
);

  localparam int CW     = COUNT_BITS;
  localparam int F      = FRACTION_BITS;
  localparam int KW     = (CW > 1) ? $clog2(CW) : 1;
  localparam int LN_W   = F + 5;
  localparam int ROOT_W = (CW + 2 * F + 1) / 2;
  localparam int RAD_W  = 2 * ROOT_W;
  localparam int RW     = ROOT_W + 3;
  localparam int RL_W   = ROOT_W / 2;
  localparam int RH_W   = ROOT_W - RL_W;
  localparam int PL_W   = SCALE_W + LN_W;
  localparam int PS_W   = SCALE_W + ROOT_W;
  localparam int EXT_W  = 2 * SCALE_W + ROOT_W;
  localparam int SH_LN  = LOG2_FRAC + 64 - F;

  logic en;
  assign en        = out_ready | ~out_valid;
  assign in_ready  = en;
  assign cfg_ready = 1'b1;

  // configuration
  logic [1:0]         mode_r;
  logic [CW-1:0]      limit_r, offset_r;
  logic [SCALE_W-1:0] scale_r;
  logic [2*SCALE_W-1:0] ssq_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= MODE_PASS;
      limit_r  <= CW'(32767);
      offset_r <= '0;
      scale_r  <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_MAP_MODE:    mode_r   <= cfg_data[1:0];
        REG_COUNT_LIMIT: limit_r  <= cfg_data[CW-1:0];
        REG_LOW_OFFSET:  offset_r <= cfg_data[CW-1:0];
        REG_SCALE:       scale_r  <= cfg_data[SCALE_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    ssq_r <= (2*SCALE_W)'(scale_r) * (2*SCALE_W)'(scale_r);
  end

  // stage 0: input register
  logic          v0_r;
  logic [CW-1:0] cnt_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
    end else if (en) begin
      v0_r <= in_valid;
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      cnt_r <= in_iteration_count;
    end
  end

  // stage 1: clamp, offset, log argument
  logic          v1_r;
  logic [CW-1:0] c1_r, x1_r, la1_r;
  logic [CW-1:0] c_nxt, x_nxt, la_nxt;
  always_comb begin
    c_nxt  = (cnt_r < limit_r) ? cnt_r : limit_r;
    x_nxt  = c_nxt - offset_r;
    la_nxt = (mode_r == MODE_PLAIN_LOG) ? c_nxt : x_nxt;
    if (la_nxt == '0) begin
      la_nxt = CW'(1);
    end
  end
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (en) begin
      v1_r <= v0_r;
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      c1_r  <= c_nxt;
      x1_r  <= x_nxt;
      la1_r <= la_nxt;
    end
  end

  // stage 2: normalize the log argument, form the root radicand
  logic          v2_r;
  logic [CW-1:0] c2_r, x2_r;
  logic [KW-1:0] k2_r;
  logic [Y_W-1:0] y2_r;
  logic [RAD_W-1:0] rad2_r;
  logic [KW-1:0] k_nxt;
  always_comb begin
    k_nxt = '0;
    for (int i = 0; i < CW; i++) begin
      if (la1_r[i]) begin
        k_nxt = KW'(i);
      end
    end
  end
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (en) begin
      v2_r <= v1_r;
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      c2_r   <= c1_r;
      x2_r   <= x1_r;
      k2_r   <= k_nxt;
      y2_r   <= Y_W'(la1_r) << (SH_W'(Y_W - 1) - SH_W'(k_nxt));
      rad2_r <= RAD_W'(x1_r) << (2 * F);
    end
  end

  // squaring and root chain
  logic                 cv   [LOG2_FRAC+1];
  logic [CW-1:0]        cc   [LOG2_FRAC+1];
  logic [CW-1:0]        cx   [LOG2_FRAC+1];
  logic [KW-1:0]        ck   [LOG2_FRAC+1];
  logic [Y_W-1:0]       cy   [LOG2_FRAC+1];
  logic [LOG2_FRAC-1:0] cf   [LOG2_FRAC+1];
  logic [RW-1:0]        crem [LOG2_FRAC+1];
  logic [ROOT_W-1:0]    crt  [LOG2_FRAC+1];
  logic [RAD_W-1:0]     crad [LOG2_FRAC+1];

  assign cv[0]   = v2_r;
  assign cc[0]   = c2_r;
  assign cx[0]   = x2_r;
  assign ck[0]   = k2_r;
  assign cy[0]   = y2_r;
  assign cf[0]   = '0;
  assign crem[0] = '0;
  assign crt[0]  = '0;
  assign crad[0] = rad2_r;

  for (genvar g = 0; g < LOG2_FRAC; g++) begin : g_iter
    lpim_iter #(
      .CW      (CW),
      .KW      (KW),
      .ROOT_W  (ROOT_W),
      .DO_ROOT (g < ROOT_W)
    ) u_iter (
      .clk     (clk),
      .rst_n   (rst_n),
      .en      (en),
      .i_valid (cv[g]),
      .i_c     (cc[g]),
      .i_x     (cx[g]),
      .i_k     (ck[g]),
      .i_y     (cy[g]),
      .i_frac  (cf[g]),
      .i_rem   (crem[g]),
      .i_root  (crt[g]),
      .i_rad   (crad[g]),
      .o_valid (cv[g+1]),
      .o_c     (cc[g+1]),
      .o_x     (cx[g+1]),
      .o_k     (ck[g+1]),
      .o_y     (cy[g+1]),
      .o_frac  (cf[g+1]),
      .o_rem   (crem[g+1]),
      .o_root  (crt[g+1]),
      .o_rad   (crad[g+1])
    );
  end

  // f1: log2 times ln2, partial products
  logic [V_W-1:0] v_log2;
  assign v_log2 = (V_W'(ck[LOG2_FRAC]) << LOG2_FRAC) | V_W'(cf[LOG2_FRAC]);

  logic              vf1_r;
  logic [CW-1:0]     cf1_r, xf1_r;
  logic [ROOT_W-1:0] rf1_r;
  logic [63:0]       p_hh_r, p_hl_r, p_lh_r, p_ll_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vf1_r <= 1'b0;
    end else if (en) begin
      vf1_r <= cv[LOG2_FRAC];
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      cf1_r  <= cc[LOG2_FRAC];
      xf1_r  <= cx[LOG2_FRAC];
      rf1_r  <= crt[LOG2_FRAC];
      p_hh_r <= 64'(v_log2[V_W-1:32]) * 64'(LN2_Q64[63:32]);
      p_hl_r <= 64'(v_log2[V_W-1:32]) * 64'(LN2_Q64[31:0]);
      p_lh_r <= 64'(v_log2[31:0]) * 64'(LN2_Q64[63:32]);
      p_ll_r <= 64'(v_log2[31:0]) * 64'(LN2_Q64[31:0]);
    end
  end

  // f2: sum to ln value
  logic [127:0] ln_sum;
  assign ln_sum = (128'(p_hh_r) << 64) + (128'(p_hl_r) << 32) + (128'(p_lh_r) << 32)
                + 128'(p_ll_r);

  logic              vf2_r;
  logic [CW-1:0]     cf2_r, xf2_r;
  logic [ROOT_W-1:0] rf2_r;
  logic [LN_W-1:0]   lnf2_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vf2_r <= 1'b0;
    end else if (en) begin
      vf2_r <= vf1_r;
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      cf2_r  <= cf1_r;
      xf2_r  <= xf1_r;
      rf2_r  <= rf1_r;
      lnf2_r <= ln_sum[SH_LN +: LN_W];
    end
  end

  // f3: palette scale products
  logic                       vf3_r;
  logic [CW-1:0]              cf3_r, xf3_r;
  logic [PL_W-1:0]            pl_r;
  logic [SCALE_W+RL_W-1:0]    prl_r;
  logic [SCALE_W+RH_W-1:0]    prh_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vf3_r <= 1'b0;
    end else if (en) begin
      vf3_r <= vf2_r;
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      cf3_r <= cf2_r;
      xf3_r <= xf2_r;
      pl_r  <= PL_W'(scale_r) * PL_W'(lnf2_r);
      prl_r <= (SCALE_W+RL_W)'(scale_r) * (SCALE_W+RL_W)'(rf2_r[RL_W-1:0]);
      prh_r <= (SCALE_W+RH_W)'(scale_r) * (SCALE_W+RH_W)'(rf2_r[ROOT_W-1:RL_W]);
    end
  end

  // f4: curve select into the output register
  logic [DATA_W-1:0] res_nxt;
  always_comb begin
    logic [EXT_W-1:0] c_e, x_e, off_e, ql_e, qs_e, ssq_e;
    logic [PS_W-1:0]  ps;
    ps    = (PS_W'(prh_r) << RL_W) + PS_W'(prl_r);
    c_e   = EXT_W'(cf3_r);
    x_e   = EXT_W'(xf3_r);
    off_e = EXT_W'(offset_r);
    ql_e  = EXT_W'(pl_r) >> (2 * F);
    qs_e  = EXT_W'(ps) >> (2 * F);
    ssq_e = EXT_W'(ssq_r) >> (2 * F);
    case (mode_r)
      MODE_PASS: begin
        res_nxt = DATA_W'(c_e);
      end
      MODE_OFFSET_LOG: begin
        if (c_e <= off_e + EXT_W'(1)) begin
          res_nxt = DATA_W'(1);
        end else if (x_e <= ql_e) begin
          res_nxt = DATA_W'(x_e);
        end else begin
          res_nxt = DATA_W'(ql_e + EXT_W'(1));
        end
      end
      MODE_PLAIN_LOG: begin
        if (c_e == '0) begin
          res_nxt = DATA_W'(1);
        end else begin
          res_nxt = DATA_W'(ql_e + EXT_W'(1));
        end
      end
      default: begin
        if (c_e <= off_e) begin
          res_nxt = DATA_W'(1);
        end else if (x_e <= ssq_e) begin
          res_nxt = DATA_W'(x_e + EXT_W'(1));
        end else begin
          res_nxt = DATA_W'(qs_e + EXT_W'(1));
        end
      end
    endcase
  end

  logic              out_valid_r;
  logic [DATA_W-1:0] out_idx_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= vf3_r;
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      out_idx_r <= res_nxt;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_color_index = out_idx_r;

endmodule

// ===== verif/log_palette_index_map_tb.sv =====
// ----------------------------------------------------------------------------
// log_palette_index_map_tb
// Self-checking bench for the palette index map: drives iteration counts under
// every mapping mode and several register settings, predicts each palette
// index in fixed point and compares it with the result beat, with random
// idling on both sides, a long receiver hold-off and a full drain pause.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module log_palette_index_map_tb import lpim_pkg::*; ();

  localparam int LATENCY   = 130;
  localparam int WDOG_MAX  = 20000;
  localparam int IDLE_PCT  = 38;

  logic                 clk;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_ready;
  logic [31:0]          in_iteration_count;
  logic                 out_valid;
  logic                 out_ready;
  logic [DATA_W-1:0]    out_color_index;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [DATA_W-1:0]    cfg_data;

  logic [1:0]  cur_mode;
  logic [63:0] cur_limit;
  logic [63:0] cur_offset;
  logic [63:0] cur_scale;

  logic [31:0] index_q[$];
  int          err_cnt;
  int          stall_cnt;
  bit          calm;
  bit          rx_hold;

  log_palette_index_map u_dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_iteration_count (in_iteration_count),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_color_index    (out_color_index),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data)
  );

  always #5 clk = ~clk;

  // floor(ln(x) * 2^16), x >= 1
  function automatic logic [63:0] ln_q16(logic [63:0] x);
    int          k;
    logic [63:0] y;
    logic [63:0] frac;
    logic [127:0] p;
    k = 0;
    while (k < 63 && (x >> (k + 1)) != 0) k++;
    y = x << (61 - k);
    frac = '0;
    for (int i = 0; i < LOG2_FRAC; i++) begin
      p = {64'd0, y} * {64'd0, y};
      y = p[124:61];
      frac = frac << 1;
      if (y >= 64'h4000_0000_0000_0000) begin
        y = y >> 1;
        frac = frac | 64'd1;
      end
    end
    p = {64'd0, (64'(k) << LOG2_FRAC) | frac} * {64'd0, LN2_Q64};
    p = p >> 104;
    return p[63:0];
  endfunction

  // floor(sqrt(x) * 2^16), x < 2^32
  function automatic logic [63:0] sqrt_q16(logic [63:0] x);
    logic [127:0] t;
    logic [63:0]  r;
    logic [63:0]  c;
    t = {64'd0, x} << 32;
    r = '0;
    for (int b = 47; b >= 0; b--) begin
      c = r | (64'd1 << b);
      if ({64'd0, c} * {64'd0, c} <= t) r = c;
    end
    return r;
  endfunction

  function automatic logic [63:0] scaled_floor(logic [63:0] a, logic [63:0] b);
    logic [127:0] p;
    p = ({64'd0, a} * {64'd0, b}) >> 32;
    return p[63:0];
  endfunction

  function automatic logic [31:0] palette_index(logic [31:0] count);
    logic [63:0] c;
    logic [63:0] x;
    logic [63:0] q;
    logic [63:0] r;
    c = ({32'd0, count} < cur_limit) ? {32'd0, count} : cur_limit;
    case (cur_mode)
      MODE_PASS: r = c;
      MODE_OFFSET_LOG: begin
        if (c <= cur_offset + 64'd1) r = 64'd1;
        else begin
          x = c - cur_offset;
          q = scaled_floor(cur_scale, ln_q16(x));
          r = (x <= q) ? x : q + 64'd1;
        end
      end
      MODE_PLAIN_LOG: begin
        if (c == 0) r = 64'd1;
        else r = scaled_floor(cur_scale, ln_q16(c)) + 64'd1;
      end
      default: begin
        if (c <= cur_offset) r = 64'd1;
        else begin
          x = c - cur_offset;
          if (x <= scaled_floor(cur_scale, cur_scale)) r = x + 64'd1;
          else r = scaled_floor(cur_scale, sqrt_q16(x)) + 64'd1;
        end
      end
    endcase
    return r[31:0];
  endfunction

  // result checker
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (index_q.size() == 0) begin
        $error("color_index: no beat expected, actual %0d", out_color_index);
        err_cnt++;
      end else begin
        if (out_color_index !== index_q[0]) begin
          $error("color_index: expected %0d, actual %0d", index_q[0], out_color_index);
          err_cnt++;
        end
        void'(index_q.pop_front());
      end
    end
  end

  // receiver
  always @(negedge clk) begin
    if (rx_hold) out_ready <= 1'b0;
    else if (calm) out_ready <= 1'b1;
    else out_ready <= ($urandom_range(99) >= IDLE_PCT);
  end

  // watchdog
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_valid && cfg_ready)) begin
      stall_cnt <= 0;
    end else if (stall_cnt >= WDOG_MAX) begin
      $display("[FAIL] regression broken");
      $finish;
    end else begin
      stall_cnt <= stall_cnt + 1;
    end
  end

  task automatic send_count(logic [31:0] v);
    @(negedge clk);
    while (!calm && $urandom_range(99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_iteration_count <= v;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    index_q.push_back(palette_index(v));
  endtask

  task automatic wait_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    wait (index_q.size() == 0);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] v);
    wait_drained();
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      REG_MAP_MODE:    cur_mode   = v[1:0];
      REG_COUNT_LIMIT: cur_limit  = {32'd0, v};
      REG_LOW_OFFSET:  cur_offset = {32'd0, v};
      default:         cur_scale  = {39'd0, v[SCALE_W-1:0]};
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic set_all(logic [1:0] m, logic [31:0] lim, logic [31:0] off,
                         logic [31:0] s);
    write_reg(REG_MAP_MODE, 32'(m));
    write_reg(REG_COUNT_LIMIT, lim);
    write_reg(REG_LOW_OFFSET, off);
    write_reg(REG_SCALE, s);
  endtask

  function automatic logic [31:0] rand_count();
    case ($urandom_range(3))
      0: return $urandom_range(300);
      1: return cur_offset[31:0] + $urandom_range(40) - 20;
      2: return $urandom_range(70000);
      default: return $urandom;
    endcase
  endfunction

  task automatic test_reset_defaults();
    send_count(32'd0);
    send_count(32'd32767);
    send_count(32'hFFFF_FFFF);
  endtask

  task automatic test_pass_through();
    set_all(MODE_PASS, 32'hFFFF_FFFF, 32'd0, 32'd0);
    send_count(32'hFFFF_FFFF);
    send_count(32'h5555_AAAA);
    write_reg(REG_COUNT_LIMIT, 32'd0);
    send_count(32'h1234);
  endtask

  task automatic test_offset_log();
    set_all(MODE_OFFSET_LOG, 32'hFFFF_FFFF, 32'd10, 32'h0002_8000);
    send_count(32'd11);
    send_count(32'd12);
    send_count(32'd500);
    send_count(32'hFFFF_FFFF);
    write_reg(REG_LOW_OFFSET, 32'hFFFF_FFFE);
    send_count(32'hFFFF_FFFF);
    write_reg(REG_SCALE, 32'h01FF_FFFF);
    write_reg(REG_LOW_OFFSET, 32'd0);
    send_count(32'd3);
    send_count(32'hFFFF_FFFF);
  endtask

  task automatic test_plain_log();
    set_all(MODE_PLAIN_LOG, 32'hFFFF_FFFF, 32'd0, 32'h01FF_FFFF);
    send_count(32'd0);
    send_count(32'd1);
    send_count(32'hFFFF_FFFF);
    write_reg(REG_SCALE, 32'd0);
    send_count(32'd1000);
  endtask

  task automatic test_sqrt();
    set_all(MODE_SQRT, 32'hFFFF_FFFF, 32'd5, 32'h0004_0000);
    send_count(32'd5);
    send_count(32'd6);
    send_count(32'd21);
    send_count(32'd22);
    send_count(32'hFFFF_FFFF);
    write_reg(REG_SCALE, 32'h01FF_FFFF);
    send_count(32'hFFFF_FFFF);
  endtask

  task automatic test_random(int phases, int per_phase);
    for (int p = 0; p < phases; p++) begin
      calm = (p == 2);
      set_all(2'($urandom_range(3)),
              ($urandom_range(3) == 0) ? 32'hFFFF_FFFF : $urandom_range(1, 100000),
              ($urandom_range(2) == 0) ? 32'd0 : $urandom_range(0, 2000),
              ($urandom_range(4) == 0) ? $urandom_range(0, 32'h01FF_FFFF)
                                       : $urandom_range(0, 32'h0010_0000));
      for (int i = 0; i < per_phase; i++) send_count(rand_count());
    end
    calm = 0;
  endtask

  task automatic test_backpressure();
    set_all(MODE_SQRT, 32'hFFFF_FFFF, 32'd3, 32'h0003_0000);
    fork
      begin
        rx_hold = 1;
        repeat (400) @(negedge clk);
        rx_hold = 0;
      end
      for (int i = 0; i < 180; i++) send_count(rand_count());
    join
  endtask

  task automatic test_drain_pause();
    for (int i = 0; i < 30; i++) send_count($urandom);
    wait_drained();
    for (int i = 0; i < 30; i++) send_count(rand_count());
  endtask

  initial begin
    clk = 0;
    rst_n = 0;
    in_valid = 0;
    in_iteration_count = '0;
    out_ready = 0;
    cfg_valid = 0;
    cfg_index = '0;
    cfg_data = '0;
    err_cnt = 0;
    stall_cnt = 0;
    calm = 0;
    rx_hold = 0;
    cur_mode = MODE_PASS;
    cur_limit = 64'd32767;
    cur_offset = '0;
    cur_scale = '0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n = 1;

    test_reset_defaults();
    test_pass_through();
    test_offset_log();
    test_plain_log();
    test_sqrt();
    test_random(8, 60);
    test_backpressure();
    test_drain_pause();

    wait_drained();
    repeat (LATENCY) @(posedge clk);
    if (err_cnt == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hdl/lpim_pkg.sv
hdl/lpim_iter.sv
hdl/log_palette_index_map.sv
verif/log_palette_index_map_tb.sv
